>>> rtl/assert_macros.svh
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_ALWAYS(label, clk, rstn, expr) \
	label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
		else $error("invariant violated");

`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("implication violated");

`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`else

`define ASSERT_ALWAYS(label, clk, rstn, expr)
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

>>> rtl/vrr_pkg.sv
package vrr_pkg;

	localparam int MAX_CELLS  = 64;
	localparam int COORD_BITS = 16;
	localparam int CNT_W      = $clog2(MAX_CELLS + 1);
	localparam int DATA_W     = ((3 * COORD_BITS + 7) / 8) * 8;

	localparam logic [1:0] AXIS_X    = 2'd0;
	localparam logic [1:0] AXIS_Y    = 2'd1;
	localparam logic [1:0] AXIS_Z    = 2'd2;
	localparam logic [1:0] AXIS_NONE = 2'd3;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t z;
		coord_t y;
		coord_t x;
	} cell_t;

	typedef struct packed {
		logic       enable;
		logic [1:0] axis;
		logic       cw;
	} rot_cfg_t;

	localparam coord_t COORD_MAX = coord_t'({1'b0, {(COORD_BITS-1){1'b1}}});
	localparam coord_t COORD_MIN = coord_t'({1'b1, {(COORD_BITS-1){1'b0}}});

	function automatic coord_t neg_sat(coord_t a);
		coord_t r;
		if (a == COORD_MIN) begin
			r = COORD_MAX;
		end else begin
			r = -a;
		end
		return r;
	endfunction

	function automatic coord_t sub_sat(coord_t a, coord_t b);
		logic signed [COORD_BITS:0] d;
		coord_t r;
		d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
		if (d[COORD_BITS] != d[COORD_BITS-1]) begin
			r = d[COORD_BITS] ? COORD_MIN : COORD_MAX;
		end else begin
			r = d[COORD_BITS-1:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/vrr_cell.sv
module vrr_cell (
	input  logic          clk,
	input  logic          shift,
	input  logic          write,
	input  vrr_pkg::cell_t nbr,
	input  vrr_pkg::cell_t wdata,
	output vrr_pkg::cell_t data
);
	import vrr_pkg::*;

	cell_t data_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= nbr;
		end else if (write) begin
			data_q <= wdata;
		end
	end

	assign data = data_q;

endmodule

>>> rtl/vrr_rotate.sv
module vrr_rotate (
	input  vrr_pkg::rot_cfg_t cfg,
	input  vrr_pkg::cell_t    cin,
	output vrr_pkg::cell_t    cout
);
	import vrr_pkg::*;

	always_comb begin
		cout = cin;
		if (cfg.enable) begin
			case (cfg.axis)
				AXIS_X: begin
					cout.y = cfg.cw ? neg_sat(cin.z) : cin.z;
					cout.z = cfg.cw ? cin.y : neg_sat(cin.y);
				end
				AXIS_Y: begin
					cout.x = cfg.cw ? cin.z : neg_sat(cin.z);
					cout.z = cfg.cw ? neg_sat(cin.x) : cin.x;
				end
				AXIS_Z: begin
					cout.x = cfg.cw ? neg_sat(cin.y) : cin.y;
					cout.y = cfg.cw ? cin.x : neg_sat(cin.x);
				end
				default: begin
					cout = cin;
				end
			endcase
		end
	end

endmodule

>>> rtl/voxel_rotate_and_recenter.sv
// Rotate-and-recenter for a set of 3D cell coordinates.
// s_axis carries one cell per word (tdata: cell_x, cell_y, cell_z from bit 0),
// tlast marks the final cell of the set. Cells load at one word per cycle;
// each is rotated by the current cfg settings and the bounding box is updated
// as it is stored in a row of MAX_CELLS shift cells. Cells past MAX_CELLS are
// dropped and flagged.
// After the final word, s_axis_tready drops; ST_CENTER forms the center
// floor((min+max)/2), or zero when rotation is on with axis AXIS_NONE; then
// the stored cells stream out on m_axis, oldest first, one word per cycle
// while m_axis_tready allows, as the cell row shifts toward its head.
// m_axis is a registered stage: when m_axis_tready is low, the word holds and
// the cell row stops shifting. s_axis_tready is low until the whole set has
// been handed to the output register.
// cfg: cfg_index 0 rotate_enable, 1 rotate_axis, 2 rotate_clockwise; other
// indexes are ignored. cfg_ready is always high.
// Reset clears the cell count, drop flag, output valid and config registers
// (rotation off, axis Z, anticlockwise); stored cells need no clearing.
module voxel_rotate_and_recenter (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [vrr_pkg::DATA_W-1:0] s_axis_tdata,  // cell_x, cell_y, cell_z
	input  logic                       s_axis_tlast,  // final_cell
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [vrr_pkg::DATA_W-1:0] m_axis_tdata,  // out_x, out_y, out_z
	output logic                       m_axis_tlast,  // run_end
	output logic                       m_axis_tuser,  // overflowed
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [1:0]                 cfg_data
);
	import vrr_pkg::*;
	`include "assert_macros.svh"

	localparam logic [1:0] REG_ROT_EN   = 2'd0;
	localparam logic [1:0] REG_ROT_AXIS = 2'd1;
	localparam logic [1:0] REG_ROT_CW   = 2'd2;

	typedef enum logic [1:0] {ST_LOAD, ST_CENTER, ST_EMIT} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] left_q;
	logic             drop_q;
	logic             no_center_q;
	cell_t            low_q;
	cell_t            high_q;
	cell_t            center_q;
	rot_cfg_t         cfg_q;
	logic             m_valid_q;
	logic             m_last_q;
	logic             m_user_q;
	cell_t            m_cell_q;

	cell_t            in_cell;
	cell_t            rot_cell;
	cell_t            head;
	cell_t            cell_data [MAX_CELLS];
	logic             in_acc;
	logic             has_room;
	logic             store;
	logic             emit_go;
	logic             shift;
	logic signed [COORD_BITS:0] sum_x, sum_y, sum_z;

	assign in_cell.x = s_axis_tdata[COORD_BITS-1:0];
	assign in_cell.y = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
	assign in_cell.z = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];

	assign s_axis_tready = (state_q == ST_LOAD);
	assign cfg_ready     = 1'b1;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign has_room      = (count_q < CNT_W'(MAX_CELLS));
	assign store         = in_acc && has_room;
	assign emit_go       = (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready);
	assign shift         = emit_go;

	vrr_rotate u_rot (
		.cfg  (cfg_q),
		.cin  (in_cell),
		.cout (rot_cell)
	);

	for (genvar i = 0; i < MAX_CELLS; i++) begin : g_cell
		cell_t nbr;
		if (i == MAX_CELLS - 1) begin : g_tail
			assign nbr = cell_data[i];
		end else begin : g_mid
			assign nbr = cell_data[i+1];
		end
		vrr_cell u_cell (
			.clk   (clk),
			.shift (shift),
			.write (store && (count_q == CNT_W'(i))),
			.nbr   (nbr),
			.wdata (rot_cell),
			.data  (cell_data[i])
		);
	end

	assign head  = cell_data[0];
	assign sum_x = {low_q.x[COORD_BITS-1], low_q.x} + {high_q.x[COORD_BITS-1], high_q.x};
	assign sum_y = {low_q.y[COORD_BITS-1], low_q.y} + {high_q.y[COORD_BITS-1], high_q.y};
	assign sum_z = {low_q.z[COORD_BITS-1], low_q.z} + {high_q.z[COORD_BITS-1], high_q.z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable <= 1'b0;
			cfg_q.axis   <= AXIS_Z;
			cfg_q.cw     <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ROT_EN:   cfg_q.enable <= cfg_data[0];
				REG_ROT_AXIS: cfg_q.axis   <= cfg_data;
				REG_ROT_CW:   cfg_q.cw     <= cfg_data[0];
				default:      cfg_q        <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (store) begin
			if (count_q == '0 || rot_cell.x < low_q.x) low_q.x <= rot_cell.x;
			if (count_q == '0 || rot_cell.y < low_q.y) low_q.y <= rot_cell.y;
			if (count_q == '0 || rot_cell.z < low_q.z) low_q.z <= rot_cell.z;
			if (count_q == '0 || rot_cell.x > high_q.x) high_q.x <= rot_cell.x;
			if (count_q == '0 || rot_cell.y > high_q.y) high_q.y <= rot_cell.y;
			if (count_q == '0 || rot_cell.z > high_q.z) high_q.z <= rot_cell.z;
		end
		if (state_q == ST_CENTER) begin
			if (no_center_q) begin
				center_q <= '0;
			end else begin
				center_q.x <= sum_x[COORD_BITS:1];
				center_q.y <= sum_y[COORD_BITS:1];
				center_q.z <= sum_z[COORD_BITS:1];
			end
		end
		if (emit_go) begin
			m_cell_q.x <= sub_sat(head.x, center_q.x);
			m_cell_q.y <= sub_sat(head.y, center_q.y);
			m_cell_q.z <= sub_sat(head.z, center_q.z);
			m_last_q   <= (left_q == CNT_W'(1));
			m_user_q   <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			left_q      <= '0;
			drop_q      <= 1'b0;
			no_center_q <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			if (emit_go) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (has_room) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							drop_q <= 1'b1;
						end
						if (s_axis_tlast) begin
							no_center_q <= cfg_q.enable && (cfg_q.axis == AXIS_NONE);
							state_q     <= ST_CENTER;
						end
					end
				end
				ST_CENTER: begin
					left_q  <= count_q;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						left_q <= left_q - CNT_W'(1);
						if (left_q == CNT_W'(1)) begin
							count_q <= '0;
							drop_q  <= 1'b0;
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = DATA_W'({m_cell_q.z, m_cell_q.y, m_cell_q.x});
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tuser  = m_user_q;

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_W'(MAX_CELLS))
	`ASSERT_IMPLIES(a_load_idle, clk, arst_n, state_q == ST_LOAD, left_q == '0)
	`ASSERT_NEXT(a_set_done, clk, arst_n, emit_go && (left_q == CNT_W'(1)), (state_q == ST_LOAD) && (count_q == '0) && m_axis_tlast)
	`ASSERT_NEXT(a_drop_set, clk, arst_n, in_acc && !has_room && !s_axis_tlast, drop_q)

endmodule
